@@ src/ect_pkg.sv @@
// ----------------------------------------------------------------------------
// ect_pkg
// Shared types and token codes of the expression character tokenizer.
// ----------------------------------------------------------------------------
package ect_pkg;

    // token kinds
    localparam logic [3:0] KIND_COMMENT = 4'd0;
    localparam logic [3:0] KIND_NUMBER  = 4'd1;
    localparam logic [3:0] KIND_LPAREN  = 4'd2;
    localparam logic [3:0] KIND_RPAREN  = 4'd3;
    localparam logic [3:0] KIND_EQUAL   = 4'd4;
    localparam logic [3:0] KIND_NEWLINE = 4'd5;
    localparam logic [3:0] KIND_ADD     = 4'd6;
    localparam logic [3:0] KIND_SUB     = 4'd7;
    localparam logic [3:0] KIND_MUL     = 4'd8;
    localparam logic [3:0] KIND_DIV     = 4'd9;
    localparam logic [3:0] KIND_END     = 4'd10;
    localparam logic [3:0] KIND_ERROR   = 4'd11;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_LONG    = 2'd1;
    localparam logic [1:0] ERR_INVALID = 2'd2;
    localparam logic [1:0] ERR_SYNTAX  = 2'd3;

    typedef struct packed {
        logic [7:0] character;
        logic       first_of_line;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [31:0] mantissa;
        logic [7:0]  fraction_digits;
        logic        mantissa_saturated;
        logic [1:0]  error_code;
        logic        last;
    } result_t;

    // up to two results caused by one character, in delivery order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

endpackage

@@ src/ect_char_if.sv @@
// ----------------------------------------------------------------------------
// ect_char_if
// Character channel: one text byte with line start and end of text marks.
// ----------------------------------------------------------------------------
interface ect_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       first_of_line;
    logic       end_of_text;

    modport source (output valid, character, first_of_line, end_of_text, input ready);
    modport sink   (input valid, character, first_of_line, end_of_text, output ready);
endinterface

@@ src/ect_token_if.sv @@
// ----------------------------------------------------------------------------
// ect_token_if
// Token channel: one token with number payload and error code.
// ----------------------------------------------------------------------------
interface ect_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] mantissa;
    logic [7:0]  fraction_digits;
    logic        mantissa_saturated;
    logic [1:0]  error_code;
    logic        last;

    modport source (output valid, token_kind, mantissa, fraction_digits,
                    mantissa_saturated, error_code, last, input ready);
    modport sink   (input valid, token_kind, mantissa, fraction_digits,
                    mantissa_saturated, error_code, last, output ready);
endinterface

@@ src/ect_lexer_core.sv @@
// ----------------------------------------------------------------------------
// ect_lexer_core
// Lexer state and the single-pass next-state / token logic for one character.
// ----------------------------------------------------------------------------
module ect_lexer_core #(
    parameter int MAX_TOKEN_LENGTH = 256,
    parameter int MANTISSA_BITS    = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ect_pkg::item_t       item,
    input  logic                 fire,
    output ect_pkg::result_pair_t pair
);
    import ect_pkg::*;

    localparam int MANT_W = (MANTISSA_BITS < 32) ? MANTISSA_BITS : 32;
    localparam int LEN_W  = $clog2(MAX_TOKEN_LENGTH);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_TOKEN_LENGTH - 1);

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_INT  = 3'd1;
    localparam logic [2:0] ST_DOT  = 3'd2;
    localparam logic [2:0] ST_FRAC = 3'd3;
    localparam logic [2:0] ST_LP   = 3'd4;
    localparam logic [2:0] ST_RP   = 3'd5;
    localparam logic [2:0] ST_EQ   = 3'd6;
    localparam logic [2:0] ST_STR  = 3'd7;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    logic [2:0]        state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [MANT_W-1:0] acc_reg, acc_next;
    logic [7:0]        frac_reg, frac_next;
    logic              sat_reg, sat_next;
    logic              halted_reg, halted_next;

    logic [7:0]        c;
    logic              is_digit, is_op, is_blank, is_lf, is_dot, is_eq;
    logic [2:0]        st_cur, st_pc;
    logic [LEN_W-1:0]  len_cur, len_pc;
    logic [MANT_W-1:0] acc_cur, acc_pc;
    logic [7:0]        frac_cur;
    logic              sat_cur, halt_cur;
    logic [MANT_W+3:0] acc_x10;
    logic              acc_ovf;
    logic              pend_valid;
    logic [3:0]        pend_kind;
    logic              pre_fail, do_close, clear_all;
    logic              close_emit, own_emit;
    logic [3:0]        close_kind, own_kind;
    logic [1:0]        own_err;
    result_t           close_res, own_res;

    always_comb
    begin
        c        = item.character;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_op    = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
        is_lf    = (c == CH_LF);
        is_blank = (c == CH_SPACE) || (c == CH_TAB) || is_lf || (c == CH_VT)
                   || (c == CH_FF) || (c == CH_CR);
        is_dot   = (c == CH_DOT);
        is_eq    = (c == CH_EQUAL);

        // a line start drops whatever was pending and lifts the halt
        st_cur   = item.first_of_line ? ST_INIT : state_reg;
        len_cur  = item.first_of_line ? '0 : len_reg;
        acc_cur  = item.first_of_line ? '0 : acc_reg;
        frac_cur = item.first_of_line ? '0 : frac_reg;
        sat_cur  = item.first_of_line ? 1'b0 : sat_reg;
        halt_cur = item.first_of_line ? 1'b0 : halted_reg;

        unique case (st_cur)
            ST_INT, ST_FRAC:
            begin
                pend_valid = 1'b1;
                pend_kind  = KIND_NUMBER;
            end
            ST_LP:
            begin
                pend_valid = 1'b1;
                pend_kind  = KIND_LPAREN;
            end
            ST_RP:
            begin
                pend_valid = 1'b1;
                pend_kind  = KIND_RPAREN;
            end
            ST_EQ:
            begin
                pend_valid = 1'b1;
                pend_kind  = KIND_EQUAL;
            end
            default:
            begin
                pend_valid = 1'b0;
                pend_kind  = KIND_NUMBER;
            end
        endcase

        pre_fail = ((st_cur == ST_LP) && (is_op || is_dot || is_eq))
                   || ((st_cur == ST_RP) && (is_dot || is_eq));
        do_close = (((st_cur == ST_INT) || (st_cur == ST_FRAC)) && !is_digit && !is_dot)
                   || (st_cur == ST_LP) || (st_cur == ST_RP) || (st_cur == ST_EQ);
        st_pc  = do_close ? ST_INIT : st_cur;
        len_pc = do_close ? '0 : len_cur;
        acc_pc = do_close ? '0 : acc_cur;

        acc_x10 = ({4'b0000, acc_pc} << 3) + ({4'b0000, acc_pc} << 1)
                  + (MANT_W+4)'(c[3:0]);
        acc_ovf = |acc_x10[MANT_W+3:MANT_W];

        close_emit  = 1'b0;
        close_kind  = pend_kind;
        own_emit    = 1'b0;
        own_kind    = KIND_END;
        own_err     = ERR_NONE;
        clear_all   = 1'b0;
        state_next  = st_cur;
        len_next    = len_cur;
        acc_next    = acc_cur;
        frac_next   = frac_cur;
        sat_next    = sat_cur;
        halted_next = halt_cur;

        if (item.end_of_text)
        begin
            close_emit  = pend_valid;
            own_emit    = 1'b1;
            own_kind    = KIND_END;
            clear_all   = 1'b1;
            halted_next = 1'b0;
        end
        else if (!halt_cur)
        begin
            if (item.first_of_line && (c == CH_SEMI))
            begin
                own_emit    = 1'b1;
                own_kind    = KIND_COMMENT;
                clear_all   = 1'b1;
                halted_next = 1'b1;
            end
            else if (pre_fail)
            begin
                own_emit    = 1'b1;
                own_kind    = KIND_ERROR;
                own_err     = ERR_SYNTAX;
                clear_all   = 1'b1;
                halted_next = 1'b1;
            end
            else
            begin
                close_emit = do_close;
                if (do_close)
                begin
                    state_next = ST_INIT;
                    len_next   = '0;
                    acc_next   = '0;
                    frac_next  = '0;
                    sat_next   = 1'b0;
                end
                priority if (is_lf)
                begin
                    own_emit  = 1'b1;
                    own_kind  = KIND_NEWLINE;
                    clear_all = 1'b1;
                end
                else if (is_blank)
                begin
                    own_emit = 1'b0;
                end
                else if (len_pc >= LEN_LIMIT)
                begin
                    own_emit    = 1'b1;
                    own_kind    = KIND_ERROR;
                    own_err     = ERR_LONG;
                    clear_all   = 1'b1;
                    halted_next = 1'b1;
                end
                else
                begin
                    len_next = len_pc + LEN_W'(1);
                    priority if (is_op)
                    begin
                        own_emit  = 1'b1;
                        clear_all = 1'b1;
                        priority if (c == CH_PLUS)  own_kind = KIND_ADD;
                        else if (c == CH_MINUS)     own_kind = KIND_SUB;
                        else if (c == CH_STAR)      own_kind = KIND_MUL;
                        else                        own_kind = KIND_DIV;
                    end
                    else if (is_digit)
                    begin
                        // a digit after a closed paren or equal starts from zero
                        if ((st_pc == ST_INIT) || (st_pc == ST_INT))
                        begin
                            state_next = ST_INT;
                            if (acc_ovf)
                            begin
                                acc_next = {MANT_W{1'b1}};
                                sat_next = 1'b1;
                            end
                            else
                            begin
                                acc_next = acc_x10[MANT_W-1:0];
                            end
                        end
                        else if ((st_pc == ST_DOT) || (st_pc == ST_FRAC))
                        begin
                            state_next = ST_FRAC;
                            if (acc_ovf || (frac_cur == 8'hFF))
                            begin
                                sat_next = 1'b1;
                            end
                            else
                            begin
                                acc_next  = acc_x10[MANT_W-1:0];
                                frac_next = frac_cur + 8'd1;
                            end
                        end
                    end
                    else if (c == CH_LPAREN)
                    begin
                        state_next = ST_LP;
                    end
                    else if (c == CH_RPAREN)
                    begin
                        state_next = ST_RP;
                    end
                    else if (is_eq)
                    begin
                        state_next = ST_EQ;
                    end
                    else if (is_dot)
                    begin
                        if (st_pc == ST_INT)
                        begin
                            state_next = ST_DOT;
                        end
                        else
                        begin
                            own_emit    = 1'b1;
                            own_kind    = KIND_ERROR;
                            own_err     = ERR_SYNTAX;
                            clear_all   = 1'b1;
                            halted_next = 1'b1;
                        end
                    end
                    else if (c == CH_QUOTE)
                    begin
                        state_next = ST_STR;
                    end
                    else if (st_pc != ST_STR)
                    begin
                        own_emit    = 1'b1;
                        own_kind    = KIND_ERROR;
                        own_err     = ERR_INVALID;
                        clear_all   = 1'b1;
                        halted_next = 1'b1;
                    end
                end
            end
        end

        if (clear_all)
        begin
            state_next = ST_INIT;
            len_next   = '0;
            acc_next   = '0;
            frac_next  = '0;
            sat_next   = 1'b0;
        end

        close_res.token_kind         = close_kind;
        close_res.mantissa           = (close_kind == KIND_NUMBER) ? 32'(acc_cur) : 32'd0;
        close_res.fraction_digits    = (close_kind == KIND_NUMBER) ? frac_cur : 8'd0;
        close_res.mantissa_saturated = (close_kind == KIND_NUMBER) ? sat_cur : 1'b0;
        close_res.error_code         = ERR_NONE;
        close_res.last               = !own_emit;

        own_res.token_kind         = own_kind;
        own_res.mantissa           = 32'd0;
        own_res.fraction_digits    = 8'd0;
        own_res.mantissa_saturated = 1'b0;
        own_res.error_code         = own_err;
        own_res.last               = 1'b1;

        pair.count  = {1'b0, close_emit} + {1'b0, own_emit};
        pair.first  = close_emit ? close_res : own_res;
        pair.second = own_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            len_reg    <= '0;
            acc_reg    <= '0;
            frac_reg   <= '0;
            sat_reg    <= 1'b0;
            halted_reg <= 1'b0;
        end
        else if (fire)
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            acc_reg    <= acc_next;
            frac_reg   <= frac_next;
            sat_reg    <= sat_next;
            halted_reg <= halted_next;
        end
    end

    a_halt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (state_reg == ST_INIT) && (len_reg == '0))
        else $error("halted lexer holds a pending token");

    a_frac_only_in_fraction: assert property (@(posedge clk) disable iff (!rst_n)
        (frac_reg != 8'd0) |-> (state_reg == ST_FRAC))
        else $error("fraction digits counted outside fraction state");

    a_pair_closes_first: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (pair.count == 2'd2)) |->
            ((pair.first.token_kind == KIND_NUMBER) || (pair.first.token_kind == KIND_LPAREN)
             || (pair.first.token_kind == KIND_RPAREN) || (pair.first.token_kind == KIND_EQUAL)))
        else $error("two results without a pending token closed first");

endmodule

@@ src/ect_out_buffer.sv @@
// ----------------------------------------------------------------------------
// ect_out_buffer
// Two-entry result register that serializes the tokens of one character.
// ----------------------------------------------------------------------------
module ect_out_buffer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ect_pkg::result_pair_t pair,
    input  logic                  load,
    output logic                  can_take,
    ect_token_if.source           tokens
);
    import ect_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       pop;
    logic [1:0] rem_cnt;
    logic [1:0] add_cnt;

    always_comb
    begin
        pop      = (cnt_reg != 2'd0) && tokens.ready;
        rem_cnt  = cnt_reg - {1'b0, pop};
        can_take = ({1'b0, pair.count} + {1'b0, rem_cnt}) <= 3'd2;
        add_cnt  = load ? pair.count : 2'd0;
        cnt_next = rem_cnt + add_cnt;

        slot0_next = pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        if (load && (rem_cnt == 2'd0))
        begin
            slot0_next = pair.first;
            slot1_next = pair.second;
        end
        else if (load && (rem_cnt == 2'd1))
        begin
            slot1_next = pair.first;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign tokens.valid              = (cnt_reg != 2'd0);
    assign tokens.token_kind         = slot0_reg.token_kind;
    assign tokens.mantissa           = slot0_reg.mantissa;
    assign tokens.fraction_digits    = slot0_reg.fraction_digits;
    assign tokens.mantissa_saturated = slot0_reg.mantissa_saturated;
    assign tokens.error_code         = slot0_reg.error_code;
    assign tokens.last               = slot0_reg.last;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer overfilled");

    a_second_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> slot1_reg.last)
        else $error("buffered second token is not the final one of its character");

endmodule

@@ src/expression_char_tokenizer.sv @@
// ----------------------------------------------------------------------------
// expression_char_tokenizer
// Path: an accepted character passes the input register, then the result
//   register; it waits in the input register until its tokens fit there.
// Throughput: one character per cycle while the output register has room;
//   a character that yields two tokens holds the two-entry output register
//   for two output transactions.
// Reset: rst_n clears the lexer to its initial state, empties both registers.
// ----------------------------------------------------------------------------
module expression_char_tokenizer #(
    parameter int MAX_TOKEN_LENGTH = 256,
    parameter int MANTISSA_BITS    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    ect_char_if.sink    chars,
    ect_token_if.source tokens
);
    import ect_pkg::*;

    logic         in_valid_reg;
    item_t        item_reg;
    result_pair_t pair;
    logic         can_take;
    logic         fire;
    logic         in_take;

    // the registered character is processed once its tokens fit the output
    assign fire        = in_valid_reg && can_take;
    assign chars.ready = !in_valid_reg || fire;
    assign in_take     = chars.valid && chars.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.character     <= chars.character;
            item_reg.first_of_line <= chars.first_of_line;
            item_reg.end_of_text   <= chars.end_of_text;
        end
    end

    ect_lexer_core #(
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
        .MANTISSA_BITS    (MANTISSA_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_reg),
        .fire  (fire),
        .pair  (pair)
    );

    ect_out_buffer u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .pair     (pair),
        .load     (fire),
        .can_take (can_take),
        .tokens   (tokens)
    );

endmodule
